// ----- sv/ictf_pkg.sv -----
// Package with shared types, constants and the arctangent table of the tilt filter.
`default_nettype none
package ictf_pkg;

  // Parameter defaults.
  localparam int ANGLE_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  // Fixed internal widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int VEC_W      = 18;
  localparam int CORDIC_W   = 36;
  localparam int ZW         = 28;
  localparam int PW         = 42;
  localparam int ATAN_IDX_W = 5;
  localparam int DIVISOR_W  = 16;
  localparam int DIGIT_W    = 16;
  localparam int RECIP_W    = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z = 2'd2;

  // Axis codes used by the back end sequencer.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Divisors and rounding offsets.
  localparam logic [DIVISOR_W-1:0] GYRO_DIV   = 16'd16375;
  localparam logic [DIVISOR_W-1:0] GYRO_HALF  = 16'd8187;
  localparam logic [DIVISOR_W-1:0] BLEND_DIV  = 16'd250;
  localparam logic [DIVISOR_W-1:0] BLEND_HALF = 16'd125;

  // Reciprocals of the divisors, rounded up, and the product bit where each
  // quotient digit starts. Both are exact for one remainder plus one digit.
  localparam logic [RECIP_W-1:0] GYRO_RECIP  = 32'd1074331973;
  localparam logic [RECIP_W-1:0] BLEND_RECIP = 32'd17179870;
  localparam int                 GYRO_SHIFT  = 44;
  localparam int                 BLEND_SHIFT = 32;

  // Half a turn in Q16.16 degrees.
  localparam logic signed [ZW-1:0] HALF_TURN_Q16 = 28'sd11796480;

  // One input word.
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [15:0]        elapsed_ms;
  } sample_t;

  // One output word.
  typedef struct packed {
    logic signed [31:0] tilt_x;
    logic signed [31:0] tilt_y;
    logic signed [31:0] heading_z;
    logic               clipped;
  } result_t;

  // A classified sample waiting in the queue.
  typedef struct packed {
    logic signed [VEC_W-1:0] num_x;
    logic signed [VEC_W-1:0] den_x;
    logic signed [VEC_W-1:0] num_y;
    logic signed [VEC_W-1:0] den_y;
    logic                    zero_x;
    logic                    zero_y;
    logic signed [15:0]      rate_x;
    logic signed [15:0]      rate_y;
    logic signed [15:0]      rate_z;
    logic [15:0]             elapsed_ms;
  } job_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Arctangent of 2^-i in Q16.16 degrees, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 28'sd2949120;
      5'd1:    v = 28'sd1740967;
      5'd2:    v = 28'sd919879;
      5'd3:    v = 28'sd466945;
      5'd4:    v = 28'sd234379;
      5'd5:    v = 28'sd117304;
      5'd6:    v = 28'sd58666;
      5'd7:    v = 28'sd29335;
      5'd8:    v = 28'sd14668;
      5'd9:    v = 28'sd7334;
      5'd10:   v = 28'sd3667;
      5'd11:   v = 28'sd1833;
      5'd12:   v = 28'sd917;
      5'd13:   v = 28'sd458;
      5'd14:   v = 28'sd229;
      5'd15:   v = 28'sd115;
      5'd16:   v = 28'sd57;
      5'd17:   v = 28'sd29;
      5'd18:   v = 28'sd14;
      5'd19:   v = 28'sd7;
      5'd20:   v = 28'sd4;
      5'd21:   v = 28'sd2;
      5'd22:   v = 28'sd1;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/ictf_front.sv -----
// Front end: accepts samples and forms the two tilt vectors for the queue.
`default_nettype none
module ictf_front (
  input  wire logic                 sample_valid,
  output logic                      sample_ready,
  input  wire ictf_pkg::sample_t    sample,
  input  wire ictf_pkg::fifo_stat_t stat,
  output logic                      push,
  output ictf_pkg::job_t            job
);

  localparam int VW = ictf_pkg::VEC_W;

  logic signed [VW-1:0] ax, ay, az, abs_x, abs_y;

  // Take a word whenever the queue has room.
  assign sample_ready = !stat.full;
  assign push         = sample_valid && !stat.full;

  // Widen the accelerometer words and take their magnitudes.
  assign ax    = VW'(sample.accel_x);
  assign ay    = VW'(sample.accel_y);
  assign az    = VW'(sample.accel_z);
  assign abs_x = ax[VW-1] ? -ax : ax;
  assign abs_y = ay[VW-1] ? -ay : ay;

  // Numerators, denominators and zero-vector flags of both atan2 terms.
  always_comb begin
    job.num_x      = ay;
    job.den_x      = az + abs_x;
    job.num_y      = ax;
    job.den_y      = az + abs_y;
    job.zero_x     = (ay == '0) && ((az + abs_x) == '0);
    job.zero_y     = (ax == '0) && ((az + abs_y) == '0);
    job.rate_x     = sample.rate_x;
    job.rate_y     = sample.rate_y;
    job.rate_z     = sample.rate_z;
    job.elapsed_ms = sample.elapsed_ms;
  end

endmodule
`default_nettype wire

// ----- sv/ictf_fifo.sv -----
// Two-entry queue of classified samples between the front and back ends.
`default_nettype none
module ictf_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ictf_pkg::job_t       din,
  input  wire logic                 pop,
  output ictf_pkg::job_t            dout,
  output ictf_pkg::fifo_stat_t      stat
);

  ictf_pkg::job_t mem [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign dout       = mem[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
      stat.full && !pop |=> stat.full)
    else $error("queue lost an entry");
`endif

endmodule
`default_nettype wire

// ----- sv/ictf_div.sv -----
// Divider of a magnitude by one of two constants, sixteen quotient bits per step pair.
`default_nettype none
module ictf_div #(
  parameter int DVW = 48
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic                                  neg,
  input  wire logic [DVW-1:0]                        dividend,
  input  wire logic [ictf_pkg::DIVISOR_W-1:0]        divisor,
  output logic                                       done,
  output logic signed [DVW:0]                        quotient
);

  localparam int DW   = ictf_pkg::DIVISOR_W;
  localparam int GW   = ictf_pkg::DIGIT_W;
  localparam int RW   = ictf_pkg::RECIP_W;
  localparam int ND   = (DVW + GW - 1) / GW;
  localparam int PADW = ND * GW;
  localparam int NS   = 2 * ND;
  localparam int CNW  = (NS > 2) ? $clog2(NS) : 1;
  localparam int VW   = DW + GW;
  localparam int PRW  = 2 * RW;
  localparam int GS   = ictf_pkg::GYRO_SHIFT;
  localparam int BS   = ictf_pkg::BLEND_SHIFT;

  logic [PADW-1:0] work;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dvs;
  logic [RW-1:0]   recip;
  logic [PRW-1:0]  prod;
  logic [VW-1:0]   v;
  logic [GW-1:0]   qd;
  logic [VW-1:0]   qd_dvs;
  logic            blend_r, neg_r, busy;
  logic [CNW-1:0]  cnt;

  // Partial dividend: the remainder so far with the next digit appended.
  assign v      = {rem, work[PADW-1 -: GW]};
  assign recip  = blend_r ? ictf_pkg::BLEND_RECIP : ictf_pkg::GYRO_RECIP;
  assign qd     = blend_r ? prod[BS+GW-1:BS] : prod[GS+GW-1:GS];
  assign qd_dvs = VW'(qd) * VW'(dvs);

  assign quotient = neg_r ? -$signed({1'b0, work[DVW-1:0]}) : $signed({1'b0, work[DVW-1:0]});

  // Operand registers: even steps form the reciprocal product, odd steps
  // take the quotient digit and the new remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      work    <= PADW'(dividend);
      rem     <= '0;
      dvs     <= divisor;
      blend_r <= (divisor != ictf_pkg::GYRO_DIV);
      neg_r   <= neg;
    end else if (busy) begin
      if (!cnt[0]) begin
        prod <= PRW'(v) * PRW'(recip);
      end else begin
        rem  <= DW'(v - qd_dvs);
        work <= {work[PADW-GW-1:0], qd};
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNW'(NS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNW'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

// ----- sv/ictf_back.sv -----
// Back end: CORDIC atan2, gyro integration, blending and saturation of each sample.
`default_nettype none
module ictf_back #(
  parameter int ANGLE_WIDTH  = ictf_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ictf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ictf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire ictf_pkg::job_t                    head,
  input  wire ictf_pkg::fifo_stat_t              stat,
  output logic                                   pop,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output ictf_pkg::result_t                      result
);

  localparam int AW     = ANGLE_WIDTH;
  localparam int SW     = ((AW > 35) ? AW : 35) + 1;
  localparam int NW     = SW + 9;
  localparam int DVW    = (NW > 48) ? NW : 48;
  localparam int QW     = DVW + 1;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int CW     = ictf_pkg::CORDIC_W;
  localparam int ZW     = ictf_pkg::ZW;
  localparam int PW     = ictf_pkg::PW;
  localparam int VW     = ictf_pkg::VEC_W;

  localparam logic signed [QW-1:0] A_HI = QW'((64'sd1 <<< (AW - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] A_LO = -A_HI - QW'(1);
  localparam logic signed [QW-1:0] O_HI = QW'(64'sd2147483647);
  localparam logic signed [QW-1:0] O_LO = -O_HI - QW'(1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_CINIT  = 10'b0000000010,
    ST_CITER  = 10'b0000000100,
    ST_MUL    = 10'b0000001000,
    ST_GSTART = 10'b0000010000,
    ST_GWAIT  = 10'b0000100000,
    ST_BMUL   = 10'b0001000000,
    ST_BSTART = 10'b0010000000,
    ST_BWAIT  = 10'b0100000000,
    ST_FINISH = 10'b1000000000
  } state_t;

  state_t               state;
  ictf_pkg::job_t       job;
  logic [1:0]           axis;
  logic [STEP_W-1:0]    step;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz, ang_x, ang_y;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] s;
  logic signed [NW-1:0] num;
  logic signed [AW-1:0] acc_x, acc_y, acc_z;
  logic                 clip;
  logic signed [23:0]   bias_x, bias_y, bias_z;

  // Saturation helpers.
  function automatic logic signed [AW-1:0] sat_angle(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    r = (v > A_HI) ? A_HI : ((v < A_LO) ? A_LO : v);
    return AW'(r);
  endfunction

  function automatic logic hit_angle(input logic signed [QW-1:0] v);
    return (v > A_HI) || (v < A_LO);
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [AW-1:0] a);
    logic signed [QW-1:0] v;
    logic signed [QW-1:0] r;
    v = QW'(a);
    r = (v > O_HI) ? O_HI : ((v < O_LO) ? O_LO : v);
    return 32'(r);
  endfunction

  function automatic logic hit_out(input logic signed [AW-1:0] a);
    logic signed [QW-1:0] v;
    v = QW'(a);
    return (v > O_HI) || (v < O_LO);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x <= '0;
      bias_y <= '0;
      bias_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ictf_pkg::REG_BIAS_X: bias_x <= $signed(cfg_data);
        ictf_pkg::REG_BIAS_Y: bias_y <= $signed(cfg_data);
        ictf_pkg::REG_BIAS_Z: bias_z <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Operands of the current axis.
  logic signed [VW-1:0] cur_num, cur_den;
  logic                 cur_zero;
  logic signed [15:0]   rate_sel;
  logic signed [23:0]   bias_sel;
  logic signed [AW-1:0] acc_sel;
  logic signed [ZW-1:0] ang_sel;

  always_comb begin
    unique case (axis)
      ictf_pkg::AXIS_X: begin
        rate_sel = job.rate_x;
        bias_sel = bias_x;
        acc_sel  = acc_x;
        ang_sel  = ang_x;
      end
      ictf_pkg::AXIS_Y: begin
        rate_sel = job.rate_y;
        bias_sel = bias_y;
        acc_sel  = acc_y;
        ang_sel  = ang_y;
      end
      default: begin
        rate_sel = job.rate_z;
        bias_sel = bias_z;
        acc_sel  = acc_z;
        ang_sel  = '0;
      end
    endcase
    if (axis == ictf_pkg::AXIS_X) begin
      cur_num  = job.num_x;
      cur_den  = job.den_x;
      cur_zero = job.zero_x;
    end else begin
      cur_num  = job.num_y;
      cur_den  = job.den_y;
      cur_zero = job.zero_y;
    end
  end

  // CORDIC start vector, turned by half a turn when the denominator is negative.
  logic signed [VW-1:0] init_x, init_y;
  logic signed [ZW-1:0] init_z;

  always_comb begin
    if (cur_den[VW-1]) begin
      init_x = -cur_den;
      init_y = -cur_num;
      init_z = cur_num[VW-1] ? -ictf_pkg::HALF_TURN_Q16 : ictf_pkg::HALF_TURN_Q16;
    end else begin
      init_x = cur_den;
      init_y = cur_num;
      init_z = '0;
    end
  end

  // One CORDIC vectoring step.
  logic signed [CW-1:0] xs, ys, cx_n, cy_n;
  logic signed [ZW-1:0] tab, cz_n;

  assign xs  = cx >>> step;
  assign ys  = cy >>> step;
  assign tab = ictf_pkg::atan_q16(ictf_pkg::ATAN_IDX_W'(step));

  always_comb begin
    if (!cy[CW-1]) begin
      cx_n = cx + ys;
      cy_n = cy - xs;
      cz_n = cz + tab;
    end else begin
      cx_n = cx - ys;
      cy_n = cy + xs;
      cz_n = cz - tab;
    end
  end

  // Gyro product, rounded dividend and blend numerator.
  logic signed [24:0]   rate_adj;
  logic signed [PW-1:0] prod_next;
  logic signed [PW+5:0] gshift;
  logic [PW+5:0]        gmag;
  logic signed [NW-1:0] num_next;
  logic [NW-1:0]        bmag;

  assign rate_adj  = (25'(rate_sel) <<< 8) - 25'(bias_sel);
  assign prod_next = PW'(rate_adj) * PW'($signed({1'b0, job.elapsed_ms}));
  assign gshift    = {prod, 6'b0};
  assign gmag      = gshift[PW+5] ? -gshift : gshift;
  assign num_next  = (NW'(s) <<< 8) - (NW'(s) <<< 3) + NW'(s) + NW'(ang_sel);
  assign bmag      = num[NW-1] ? -num : num;

  // Shared divider.
  logic                 div_start, div_neg, div_done;
  logic [DVW-1:0]       div_dividend;
  logic [ictf_pkg::DIVISOR_W-1:0] div_divisor;
  logic signed [QW-1:0] q;

  always_comb begin
    div_start = (state == ST_GSTART) || (state == ST_BSTART);
    if (state == ST_GSTART) begin
      div_neg      = prod[PW-1];
      div_dividend = DVW'(gmag) + DVW'(ictf_pkg::GYRO_HALF);
      div_divisor  = ictf_pkg::GYRO_DIV;
    end else begin
      div_neg      = num[NW-1];
      div_dividend = DVW'(bmag) + DVW'(ictf_pkg::BLEND_HALF);
      div_divisor  = ictf_pkg::BLEND_DIV;
    end
  end

  ictf_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .neg      (div_neg),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (q)
  );

  logic signed [SW-1:0] s_sum;
  assign s_sum = SW'(acc_sel) + SW'(q);

  assign pop = (state == ST_IDLE) && !stat.empty && !result_valid;

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      axis         <= ictf_pkg::AXIS_X;
      step         <= '0;
      result_valid <= 1'b0;
      acc_x        <= '0;
      acc_y        <= '0;
      acc_z        <= '0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            axis  <= ictf_pkg::AXIS_X;
            state <= ST_CINIT;
          end
        end
        ST_CINIT: begin
          step <= '0;
          if (cur_zero) begin
            if (axis == ictf_pkg::AXIS_X) begin
              axis  <= ictf_pkg::AXIS_Y;
              state <= ST_CINIT;
            end else begin
              axis  <= ictf_pkg::AXIS_X;
              state <= ST_MUL;
            end
          end else begin
            state <= ST_CITER;
          end
        end
        ST_CITER: begin
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            if (axis == ictf_pkg::AXIS_X) begin
              axis  <= ictf_pkg::AXIS_Y;
              state <= ST_CINIT;
            end else begin
              axis  <= ictf_pkg::AXIS_X;
              state <= ST_MUL;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_MUL:    state <= ST_GSTART;
        ST_GSTART: state <= ST_GWAIT;
        ST_GWAIT: begin
          if (div_done) begin
            if (axis == ictf_pkg::AXIS_Z) begin
              acc_z <= sat_angle(QW'(s_sum));
              state <= ST_FINISH;
            end else begin
              state <= ST_BMUL;
            end
          end
        end
        ST_BMUL:   state <= ST_BSTART;
        ST_BSTART: state <= ST_BWAIT;
        ST_BWAIT: begin
          if (div_done) begin
            if (axis == ictf_pkg::AXIS_X) begin
              acc_x <= sat_angle(q);
              axis  <= ictf_pkg::AXIS_Y;
            end else begin
              acc_y <= sat_angle(q);
              axis  <= ictf_pkg::AXIS_Z;
            end
            state <= ST_MUL;
          end
        end
        ST_FINISH: begin
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          job  <= head;
          clip <= 1'b0;
        end
      end
      ST_CINIT: begin
        cx <= CW'(init_x) <<< 16;
        cy <= CW'(init_y) <<< 16;
        cz <= init_z;
        if (cur_zero) begin
          if (axis == ictf_pkg::AXIS_X) begin
            ang_x <= '0;
          end else begin
            ang_y <= '0;
          end
        end
      end
      ST_CITER: begin
        cx <= cx_n;
        cy <= cy_n;
        cz <= cz_n;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          if (axis == ictf_pkg::AXIS_X) begin
            ang_x <= cz_n;
          end else begin
            ang_y <= -cz_n;
          end
        end
      end
      ST_MUL: prod <= prod_next;
      ST_GWAIT: begin
        if (div_done) begin
          s <= s_sum;
          if (axis == ictf_pkg::AXIS_Z) begin
            clip <= clip | hit_angle(QW'(s_sum));
          end
        end
      end
      ST_BMUL: num <= num_next;
      ST_BWAIT: begin
        if (div_done) begin
          clip <= clip | hit_angle(q);
        end
      end
      ST_FINISH: begin
        result.tilt_x    <= sat_out(acc_x);
        result.tilt_y    <= sat_out(acc_y);
        result.heading_z <= sat_out(acc_z);
        result.clipped   <= clip | hit_out(acc_x) | hit_out(acc_y) | hit_out(acc_z);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("pop from an empty queue");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
      $rose(result_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");
  a_wait_has_divider: assert property (@(posedge clk) disable iff (rst)
      div_done |-> (state == ST_GWAIT) || (state == ST_BWAIT))
    else $error("divider finished while nobody waits");
`endif

endmodule
`default_nettype wire

// ----- sv/imu_complementary_tilt_filter.sv -----
// Top level of the six-axis complementary tilt filter.
//
// Usage: a sample word (accelerometer, gyro, elapsed milliseconds) enters on
// the sample channel with valid and ready. One result word (tilt_x, tilt_y,
// heading_z in Q16.16 degrees and a clipped flag) leaves on the result
// channel for each sample, in order.
// A front end forms both atan2 vectors and writes a two-entry queue; the back
// end computes two CORDIC arctangents of CORDIC_STEPS iterations each, then
// five roundings through one shared divider that yields sixteen quotient
// bits per step pair; a zero tilt vector skips its CORDIC iterations.
// The queue keeps taking words while a result waits, so sample_ready drops
// only when two samples are queued, behind a stalled result or when words
// arrive faster than the back end finishes them.
// Reset (synchronous, active high) clears the bias registers, the three
// angle accumulators, the queue and the result valid flag.
// The user writes the bias registers through cfg_we, cfg_index and cfg_data
// only while idle (unenforced by the block); an index past bias_z is ignored.
`default_nettype none
module imu_complementary_tilt_filter #(
  parameter int ANGLE_WIDTH  = ictf_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire ictf_pkg::sample_t               sample,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output ictf_pkg::result_t                    result,
  input  wire logic                            cfg_we,
  input  wire logic [ictf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ictf_pkg::CFG_DATA_W-1:0] cfg_data
);

  ictf_pkg::fifo_stat_t stat;
  ictf_pkg::job_t       job_in, job_head;
  logic                 push, pop;

  ictf_front u_front (
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .stat         (stat),
    .push         (push),
    .job          (job_in)
  );

  ictf_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job_in),
    .pop  (pop),
    .dout (job_head),
    .stat (stat)
  );

  ictf_back #(
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (job_head),
    .stat         (stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the six-axis complementary tilt filter.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ictf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STEPS = ictf_pkg::CORDIC_STEPS_DEF;
  localparam longint BIAS_MIN = -8388608;
  localparam longint BIAS_MAX = 8388352;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    ictf_pkg::sample_t s;
    bit                typed;
    ictf_pkg::result_t r;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_ready;
  ictf_pkg::sample_t sample = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  ictf_pkg::result_t result;
  logic    cfg_we = 1'b0;
  logic [ictf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ictf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Filter copy kept by the testbench.
  longint bias_q8[3];
  longint tilt_x_acc, tilt_y_acc, head_z_acc;
  ictf_pkg::result_t pending_results[$];

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int clip_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_request = 1'b0;
  int stall_left = 0;

  imu_complementary_tilt_filter i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Arctangent of 2^-i in Q16.16 degrees.
  function automatic longint atan_step(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  // Divide with rounding to nearest, ties away from zero.
  function automatic longint round_div(longint n, longint d);
    longint m;
    longint q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  // Vectoring CORDIC atan2 in Q16.16 degrees.
  function automatic longint cordic_atan2(longint y, longint x);
    longint base;
    longint z;
    longint xs;
    longint ys;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    return base + z;
  endfunction

  function automatic longint clamp32(longint v, ref bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint gyro_step(longint rate, longint bias, longint ms);
    return round_div((rate * 256 - bias) * ms * 64, 16375);
  endfunction

  // Advance the filter copy by one sample and return the expected word.
  function automatic ictf_pkg::result_t filter_sample(ictf_pkg::sample_t s);
    longint ax, ay, az, acc_x, acc_y, sx, sy, sz;
    bit clip;
    ictf_pkg::result_t r;
    clip = 1'b0;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    acc_x = cordic_atan2(ay, az + ((ax < 0) ? -ax : ax));
    acc_y = -cordic_atan2(ax, az + ((ay < 0) ? -ay : ay));
    sx = tilt_x_acc + gyro_step(longint'(s.rate_x), bias_q8[0], longint'(s.elapsed_ms));
    sy = tilt_y_acc + gyro_step(longint'(s.rate_y), bias_q8[1], longint'(s.elapsed_ms));
    sz = head_z_acc + gyro_step(longint'(s.rate_z), bias_q8[2], longint'(s.elapsed_ms));
    tilt_x_acc = clamp32(round_div(249 * sx + acc_x, 250), clip);
    tilt_y_acc = clamp32(round_div(249 * sy + acc_y, 250), clip);
    head_z_acc = clamp32(sz, clip);
    r.tilt_x = tilt_x_acc[31:0];
    r.tilt_y = tilt_y_acc[31:0];
    r.heading_z = head_z_acc[31:0];
    r.clipped = clip;
    return r;
  endfunction

  function automatic ictf_pkg::sample_t mk_sample(int ax, int ay, int az, int gx, int gy,
                                                  int gz, int ms);
    ictf_pkg::sample_t s;
    s.accel_x = ax[15:0];
    s.accel_y = ay[15:0];
    s.accel_z = az[15:0];
    s.rate_x = gx[15:0];
    s.rate_y = gy[15:0];
    s.rate_z = gz[15:0];
    s.elapsed_ms = ms[15:0];
    return s;
  endfunction

  // Random sample: mostly plausible motion, some full-range words.
  function automatic ictf_pkg::sample_t rand_sample();
    ictf_pkg::sample_t s;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    s = raw[111:0];
    if ($urandom_range(99) < 70) begin
      s.rate_x = 16'($signed($urandom_range(4000)) - 2000);
      s.rate_y = 16'($signed($urandom_range(4000)) - 2000);
      s.rate_z = 16'($signed($urandom_range(4000)) - 2000);
      s.elapsed_ms = 16'($urandom_range(40));
    end
    return s;
  endfunction

  task automatic write_reg(logic [ictf_pkg::CFG_IDX_W-1:0] idx, longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[ictf_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ictf_pkg::REG_BIAS_X) bias_q8[0] = value;
    else if (idx == ictf_pkg::REG_BIAS_Y) bias_q8[1] = value;
    else if (idx == ictf_pkg::REG_BIAS_Z) bias_q8[2] = value;
  endtask

  // Offer one word, wait for its handshake and queue what it should produce.
  task automatic send_word(ictf_pkg::sample_t s, bit typed, ictf_pkg::result_t typed_r);
    ictf_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    r = filter_sample(s);
    pending_results.push_back(typed ? typed_r : r);
    words_sent++;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_biases(longint bx, longint by, longint bz);
    write_reg(ictf_pkg::REG_BIAS_X, bx);
    write_reg(ictf_pkg::REG_BIAS_Y, by);
    write_reg(ictf_pkg::REG_BIAS_Z, bz);
  endtask

  function automatic longint rand_bias();
    longint v;
    v = longint'($urandom_range(16777215)) + BIAS_MIN;
    return (v > BIAS_MAX) ? BIAS_MAX : v;
  endfunction

  // Receiver: check each accepted word and choose the next ready level.
  always @(posedge clk) begin
    ictf_pkg::result_t exp_r;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        words_checked++;
        if (result.clipped) clip_seen++;
        if (result.tilt_x !== exp_r.tilt_x) begin
          $error("tilt_x: expected %0d, got %0d", exp_r.tilt_x, result.tilt_x);
          errors++;
        end
        if (result.tilt_y !== exp_r.tilt_y) begin
          $error("tilt_y: expected %0d, got %0d", exp_r.tilt_y, result.tilt_y);
          errors++;
        end
        if (result.heading_z !== exp_r.heading_z) begin
          $error("heading_z: expected %0d, got %0d", exp_r.heading_z, result.heading_z);
          errors++;
        end
        if (result.clipped !== exp_r.clipped) begin
          $error("clipped: expected %0b, got %0b", exp_r.clipped, result.clipped);
          errors++;
        end
      end
    end
    if (stall_request && stall_left == 0) begin
      stall_left = 3000;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Main sequence.
  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    ictf_pkg::result_t zero_r;
    bias_q8 = '{0, 0, 0};
    tilt_x_acc = 0;
    tilt_y_acc = 0;
    head_z_acc = 0;
    zero_r = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; only the first is simple enough to type in.
    row.typed = 1'b1;
    row.r = zero_r;
    row.s = mk_sample(0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    row.typed = 1'b0;
    row.s = mk_sample(0, 0, 16384, 0, 0, 0, 1);
    rows.push_back(row);
    // Negative denominators in both directions.
    row.s = mk_sample(-32768, 32767, -32768, 100, -100, 50, 10);
    rows.push_back(row);
    row.s = mk_sample(32767, -32768, -32768, -1, 1, 0, 5);
    rows.push_back(row);
    // Zero denominators with nonzero numerators, on either axis and of either sign.
    row.s = mk_sample(0, 1000, 0, 0, 0, 0, 1);
    rows.push_back(row);
    row.s = mk_sample(1000, 0, 0, 0, 0, 0, 1);
    rows.push_back(row);
    row.s = mk_sample(-1000, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    // Largest rates over the longest interval saturate upward, then downward.
    row.s = mk_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535);
    rows.push_back(row);
    row.s = mk_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535);
    rows.push_back(row);
    row.s = mk_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
    rows.push_back(row);
    row.s = mk_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
    rows.push_back(row);
    row.s = mk_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
    rows.push_back(row);
    row.s = mk_sample(0, 0, 16384, 32767, -32768, 0, 65535);
    rows.push_back(row);
    row.s = mk_sample(-1, -1, -1, -1, -1, -1, 1);
    rows.push_back(row);

    send_idle_pct = 31;
    recv_idle_pct = 81;
    foreach (rows[i]) send_word(rows[i].s, rows[i].typed, rows[i].r);
    drain();

    // Random phases, each with its own bias setting; the unused index is ignored.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_biases(BIAS_MIN, BIAS_MAX, 0);
        1: begin
          set_biases(BIAS_MAX, BIAS_MIN, BIAS_MIN);
          write_reg(REG_UNUSED, BIAS_MAX);
        end
        default: set_biases(rand_bias(), rand_bias(), rand_bias());
      endcase
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < 185; n++) begin
        if (phase == 2 && n == 20) stall_request = 1'b1;
        send_word(rand_sample(), 1'b0, zero_r);
      end
      drain();
    end

    $display("Sent %0d sample words, checked %0d result words, %0d with clipping.",
             words_sent, words_checked, clip_seen);
    $display("Covered four bias settings, both idling mixes and a long result stall.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
